@@ rtl/core/rbaa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbaa_pkg
// Shared constants, register codes and latency helpers for the rigid body
// angular acceleration block.
// ----------------------------------------------------------------------------
package rbaa_pkg;

    localparam int unsigned RBAA_WORD_BITS = 32;
    localparam int unsigned RBAA_FRAC_BITS = 16;

    // operand slice width of the pipelined multipliers
    localparam int unsigned MUL_CHUNK = 32;

    // inertia reset values, integer kg m^2
    localparam int unsigned IXX_RESET_INT = 56;
    localparam int unsigned IYY_RESET_INT = 223;
    localparam int unsigned IZZ_RESET_INT = 277;

    localparam int unsigned NUM_CFG      = 6;
    localparam int unsigned CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IXX,
        CFG_IYY,
        CFG_IZZ,
        CFG_IXY,
        CFG_IXZ,
        CFG_IYZ
    } t_cfg_idx;

    function automatic int unsigned max2(input int unsigned a, input int unsigned b);
        return (a > b) ? a : b;
    endfunction

    // cycles from operands registered to product registered
    function automatic int unsigned mul_latency(input int unsigned a_bits,
                                                input int unsigned b_bits);
        return ((a_bits + MUL_CHUNK - 1) / MUL_CHUNK) *
               ((b_bits + MUL_CHUNK - 1) / MUL_CHUNK) + 1;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/rbaa_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbaa_mul
// Pipelined signed multiplier. Operands are cut into MUL_CHUNK slices; each
// stage forms one slice product and adds the previous one into the sum.
// ----------------------------------------------------------------------------
module rbaa_mul import rbaa_pkg::*; #(
    parameter int unsigned A_BITS = 33,
    parameter int unsigned B_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic signed [A_BITS-1:0]         i_a,
    input  wire logic signed [B_BITS-1:0]         i_b,
    output logic signed [A_BITS+B_BITS-1:0]       o_p
);

    localparam int unsigned NA  = (A_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int unsigned NB  = (B_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int unsigned NS  = NA * NB;
    localparam int unsigned AXW = NA * MUL_CHUNK;
    localparam int unsigned BXW = NB * MUL_CHUNK;
    localparam int unsigned XW  = AXW + BXW + 2;
    localparam int unsigned PPW = 2 * MUL_CHUNK + 2;
    localparam int unsigned LSH = ((NS - 1) / NB + (NS - 1) % NB) * MUL_CHUNK;

    logic signed [AXW-1:0] a_ext;
    logic signed [BXW-1:0] b_ext;
    logic [AXW-1:0]        r_a   [NS];
    logic [BXW-1:0]        r_b   [NS];
    logic signed [PPW-1:0] r_pp  [NS];
    logic signed [PPW-1:0] n_pp  [NS];
    logic signed [XW-1:0]  r_acc [NS];
    logic signed [XW-1:0]  r_p;

    assign a_ext = AXW'(i_a);
    assign b_ext = BXW'(i_b);

    always_comb begin
        int unsigned ia;
        int unsigned ib;
        logic [MUL_CHUNK-1:0] av;
        logic [MUL_CHUNK-1:0] bv;
        logic signed [MUL_CHUNK:0] ca;
        logic signed [MUL_CHUNK:0] cb;
        for (int s = 0; s < NS; s++) begin
            ia = s / NB;
            ib = s % NB;
            if (s == 0) begin
                av = a_ext[ia*MUL_CHUNK +: MUL_CHUNK];
                bv = b_ext[ib*MUL_CHUNK +: MUL_CHUNK];
            end else begin
                av = r_a[s-1][ia*MUL_CHUNK +: MUL_CHUNK];
                bv = r_b[s-1][ib*MUL_CHUNK +: MUL_CHUNK];
            end
            // only the top slice carries the sign
            ca = {(ia == NA - 1) ? av[MUL_CHUNK-1] : 1'b0, av};
            cb = {(ib == NB - 1) ? bv[MUL_CHUNK-1] : 1'b0, bv};
            n_pp[s] = ca * cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]   <= a_ext;
            r_b[0]   <= b_ext;
            r_pp[0]  <= n_pp[0];
            r_acc[0] <= '0;
            for (int s = 1; s < NS; s++) begin
                r_a[s]   <= r_a[s-1];
                r_b[s]   <= r_b[s-1];
                r_pp[s]  <= n_pp[s];
                r_acc[s] <= r_acc[s-1] +
                            (XW'(r_pp[s-1]) <<< (((s - 1) / NB + (s - 1) % NB) * MUL_CHUNK));
            end
            r_p <= r_acc[NS-1] + (XW'(r_pp[NS-1]) <<< LSH);
        end
    end

    assign o_p = r_p[A_BITS+B_BITS-1:0];

endmodule
`default_nettype wire

@@ rtl/core/rbaa_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbaa_div
// Pipelined restoring divider: round to nearest (ties away from zero) of
// num / den, one quotient bit per stage, saturated to the signed word range.
// ----------------------------------------------------------------------------
module rbaa_div import rbaa_pkg::*; #(
    parameter int unsigned WORD_BITS = RBAA_WORD_BITS,
    parameter int unsigned NUM_BITS  = 64,
    parameter int unsigned DEN_BITS  = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [NUM_BITS-1:0]  i_num,
    input  wire logic [DEN_BITS-1:0]         i_den_mag,
    input  wire logic                        i_den_neg,
    output logic signed [WORD_BITS-1:0]      o_quo,
    output logic                             o_sat
);

    localparam int unsigned NXW = max2(NUM_BITS, DEN_BITS) + 2;
    localparam int unsigned RW  = max2(NXW, DEN_BITS + 1 + WORD_BITS) + 1;
    localparam int unsigned NST = WORD_BITS + 1;

    logic [NUM_BITS-1:0]  r_na;
    logic                 r_neg_a;
    logic [RW-1:0]        r_rem [NST+1];
    logic [WORD_BITS-1:0] r_q   [NST+1];
    logic                 r_big [NST+1];
    logic                 r_neg [NST+1];
    logic [RW-1:0]        n_rem [NST];
    logic [WORD_BITS-1:0] n_q   [NST];
    logic                 n_big [NST];
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] mag;
    logic                 sat;
    logic signed [WORD_BITS-1:0] r_quo;
    logic                 r_sat;

    // numerator 2|n| + |d| over divisor 2|d|; stage k tries 2|d| << k
    always_comb begin
        int unsigned k;
        logic [RW-1:0] dsh;
        logic ge;
        for (int t = 0; t < NST; t++) begin
            k = WORD_BITS - t;
            dsh = RW'(i_den_mag) << (k + 1);
            ge = (r_rem[t] >= dsh);
            n_rem[t] = r_rem[t];
            n_q[t]   = r_q[t];
            n_big[t] = r_big[t];
            if (k == WORD_BITS) begin
                n_big[t] = ge;
            end else if (ge) begin
                n_rem[t] = r_rem[t] - dsh;
                n_q[t][k] = 1'b1;
            end
        end
    end

    always_comb begin
        lim = r_neg[NST] ? (WORD_BITS'(1) << (WORD_BITS - 1))
                         : ((WORD_BITS'(1) << (WORD_BITS - 1)) - WORD_BITS'(1));
        sat = r_big[NST] || (r_q[NST] > lim);
        mag = sat ? lim : r_q[NST];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_na    <= i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : NUM_BITS'(i_num);
            r_neg_a <= i_num[NUM_BITS-1] ^ i_den_neg;
            r_rem[0] <= (RW'(r_na) << 1) + RW'(i_den_mag);
            r_q[0]   <= '0;
            r_big[0] <= 1'b0;
            r_neg[0] <= r_neg_a;
            for (int t = 0; t < NST; t++) begin
                r_rem[t+1] <= n_rem[t];
                r_q[t+1]   <= n_q[t];
                r_big[t+1] <= n_big[t];
                r_neg[t+1] <= r_neg[t];
            end
            r_quo <= r_neg[NST] ? $signed(-mag) : $signed(mag);
            r_sat <= sat;
        end
    end

    assign o_quo = r_quo;
    assign o_sat = r_sat;

endmodule
`default_nettype wire

@@ rtl/core/rigid_body_angular_acceleration.sv @@
`default_nettype none
// Item path: three slice-pipelined multiplier chains and the 33-stage quotient
// pipeline at the default 32-bit word. Throughput: one item per cycle; a
// stalled output freezes the whole item pipeline. Reset clears control state
// and loads the inertia reset values; after reset or any register write the
// input stalls while cofactors and determinant are recomputed.
// ----------------------------------------------------------------------------
// rigid_body_angular_acceleration
// Euler rotation equation: a = inv(I) * (tau - w x (I w)) with a symmetric
// inertia tensor from registers, exact products and one rounded division per axis.
// ----------------------------------------------------------------------------
module rigid_body_angular_acceleration import rbaa_pkg::*; #(
    parameter int unsigned WORD_BITS = RBAA_WORD_BITS,
    parameter int unsigned FRAC_BITS = RBAA_FRAC_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  wire logic [WORD_BITS-1:0]         i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic signed [WORD_BITS-1:0]  i_torque_x,
    input  wire logic signed [WORD_BITS-1:0]  i_torque_y,
    input  wire logic signed [WORD_BITS-1:0]  i_torque_z,
    input  wire logic signed [WORD_BITS-1:0]  i_rate_x,
    input  wire logic signed [WORD_BITS-1:0]  i_rate_y,
    input  wire logic signed [WORD_BITS-1:0]  i_rate_z,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [WORD_BITS-1:0]       o_accel_x,
    output logic signed [WORD_BITS-1:0]       o_accel_y,
    output logic signed [WORD_BITS-1:0]       o_accel_z,
    output logic                              o_singular,
    output logic                              o_saturated
);

    localparam int unsigned W   = WORD_BITS;
    localparam int unsigned MW  = W + 1;
    localparam int unsigned HP  = MW + W;
    localparam int unsigned HW  = HP + 2;
    localparam int unsigned GP  = W + HW;
    localparam int unsigned GW  = GP + 1;
    localparam int unsigned TW  = W + 2 * FRAC_BITS;
    localparam int unsigned NW  = max2(TW, GW) + 1;
    localparam int unsigned CP  = 2 * MW;
    localparam int unsigned CW  = CP + 1;
    localparam int unsigned DP  = MW + CW;
    localparam int unsigned DW  = DP + 2;
    localparam int unsigned DMW = DW + FRAC_BITS;
    localparam int unsigned UP  = CW + NW;
    localparam int unsigned UW  = UP + 2;

    localparam int unsigned LH  = mul_latency(MW, W);
    localparam int unsigned LG  = mul_latency(W, HW);
    localparam int unsigned LN  = mul_latency(CW, NW);
    localparam int unsigned LC  = mul_latency(MW, MW);
    localparam int unsigned LDT = mul_latency(MW, CW);
    localparam int unsigned LD  = W + 4;

    localparam int unsigned P_H = 1 + LH + 1;
    localparam int unsigned P_G = P_H + LG + 1;
    localparam int unsigned P_N = P_G + 1;
    localparam int unsigned P_U = P_N + LN + 1;
    localparam int unsigned P_O = P_U + LD + 1;

    localparam int unsigned DLY_W = P_H - 1;
    localparam int unsigned DLY_T = P_G - 1;
    localparam int unsigned LCFG  = LC + LDT + 3;
    localparam int unsigned CNT_W = $clog2(LCFG + 1);

    // ---------------- configuration ----------------
    logic [W-1:0]        r_cfg [NUM_CFG];
    logic [CNT_W-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_IXX] <= W'(IXX_RESET_INT) << FRAC_BITS;
            r_cfg[CFG_IYY] <= W'(IYY_RESET_INT) << FRAC_BITS;
            r_cfg[CFG_IZZ] <= W'(IZZ_RESET_INT) << FRAC_BITS;
            r_cfg[CFG_IXY] <= '0;
            r_cfg[CFG_IXZ] <= '0;
            r_cfg[CFG_IYZ] <= '0;
            r_cnt          <= CNT_W'(LCFG);
        end else begin
            if (i_cfg_we) begin
                r_cnt <= CNT_W'(LCFG);
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_IXX: r_cfg[CFG_IXX] <= i_cfg_data;
                    CFG_IYY: r_cfg[CFG_IYY] <= i_cfg_data;
                    CFG_IZZ: r_cfg[CFG_IZZ] <= i_cfg_data;
                    CFG_IXY: r_cfg[CFG_IXY] <= i_cfg_data;
                    CFG_IXZ: r_cfg[CFG_IXZ] <= i_cfg_data;
                    CFG_IYZ: r_cfg[CFG_IYZ] <= i_cfg_data;
                    default: ;
                endcase
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    logic signed [MW-1:0] m [3][3];

    always_comb begin
        m[0][0] = $signed({1'b0, r_cfg[CFG_IXX]});
        m[1][1] = $signed({1'b0, r_cfg[CFG_IYY]});
        m[2][2] = $signed({1'b0, r_cfg[CFG_IZZ]});
        m[0][1] = MW'($signed(r_cfg[CFG_IXY]));
        m[0][2] = MW'($signed(r_cfg[CFG_IXZ]));
        m[1][2] = MW'($signed(r_cfg[CFG_IYZ]));
        m[1][0] = m[0][1];
        m[2][0] = m[0][2];
        m[2][1] = m[1][2];
    end

    // cofactors: k = 00, 11, 22, 01, 02, 12 ; c = a*b - p*q
    logic signed [MW-1:0] cf_a [6];
    logic signed [MW-1:0] cf_b [6];
    logic signed [MW-1:0] cf_p [6];
    logic signed [MW-1:0] cf_q [6];
    logic signed [CP-1:0] cf_ab [6];
    logic signed [CP-1:0] cf_pq [6];
    logic signed [CW-1:0] r_cof [6];
    logic signed [CW-1:0] c [3][3];

    always_comb begin
        cf_a[0] = m[1][1]; cf_b[0] = m[2][2]; cf_p[0] = m[1][2]; cf_q[0] = m[1][2];
        cf_a[1] = m[0][0]; cf_b[1] = m[2][2]; cf_p[1] = m[0][2]; cf_q[1] = m[0][2];
        cf_a[2] = m[0][0]; cf_b[2] = m[1][1]; cf_p[2] = m[0][1]; cf_q[2] = m[0][1];
        cf_a[3] = m[0][2]; cf_b[3] = m[1][2]; cf_p[3] = m[0][1]; cf_q[3] = m[2][2];
        cf_a[4] = m[0][1]; cf_b[4] = m[1][2]; cf_p[4] = m[0][2]; cf_q[4] = m[1][1];
        cf_a[5] = m[0][1]; cf_b[5] = m[0][2]; cf_p[5] = m[0][0]; cf_q[5] = m[1][2];
    end

    for (genvar k = 0; k < 6; k++) begin : g_cof
        rbaa_mul #(.A_BITS(MW), .B_BITS(MW)) u_mul_ab (
            .i_clk (i_clk), .i_en (1'b1), .i_a (cf_a[k]), .i_b (cf_b[k]), .o_p (cf_ab[k])
        );
        rbaa_mul #(.A_BITS(MW), .B_BITS(MW)) u_mul_pq (
            .i_clk (i_clk), .i_en (1'b1), .i_a (cf_p[k]), .i_b (cf_q[k]), .o_p (cf_pq[k])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            r_cof[k] <= CW'(cf_ab[k]) - CW'(cf_pq[k]);
        end
    end

    always_comb begin
        c[0][0] = r_cof[0];
        c[1][1] = r_cof[1];
        c[2][2] = r_cof[2];
        c[0][1] = r_cof[3];
        c[0][2] = r_cof[4];
        c[1][2] = r_cof[5];
        c[1][0] = r_cof[3];
        c[2][0] = r_cof[4];
        c[2][1] = r_cof[5];
    end

    logic signed [DP-1:0] det_prod [3];
    logic signed [DW-1:0] r_det;
    logic [DMW-1:0]       r_den_mag;
    logic                 r_den_neg;
    logic                 r_sing;

    for (genvar j = 0; j < 3; j++) begin : g_det
        rbaa_mul #(.A_BITS(MW), .B_BITS(CW)) u_mul (
            .i_clk (i_clk), .i_en (1'b1), .i_a (m[0][j]), .i_b (c[0][j]), .o_p (det_prod[j])
        );
    end

    always_ff @(posedge i_clk) begin
        r_det     <= DW'(det_prod[0]) + DW'(det_prod[1]) + DW'(det_prod[2]);
        r_den_mag <= DMW'(r_det[DW-1] ? DW'(-r_det) : DW'(r_det)) << FRAC_BITS;
        r_den_neg <= r_det[DW-1];
        r_sing    <= (r_det == '0);
    end

    // ---------------- item pipeline ----------------
    logic             en;
    logic             accept;
    logic [P_O:1]     r_vld;

    assign en         = !(r_vld[P_O] && i_out_stall);
    assign o_in_stall = !en || (r_cnt != '0) || i_cfg_we;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[P_O-1:1], accept};
        end
    end

    logic signed [W-1:0] r_tau1 [3];
    logic signed [W-1:0] r_w1   [3];
    logic signed [W-1:0] r_wd   [DLY_W][3];
    logic signed [W-1:0] r_td   [DLY_T][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tau1[0] <= i_torque_x;
            r_tau1[1] <= i_torque_y;
            r_tau1[2] <= i_torque_z;
            r_w1[0]   <= i_rate_x;
            r_w1[1]   <= i_rate_y;
            r_w1[2]   <= i_rate_z;
            r_wd[0]   <= r_w1;
            r_td[0]   <= r_tau1;
            for (int k = 1; k < DLY_W; k++) r_wd[k] <= r_wd[k-1];
            for (int k = 1; k < DLY_T; k++) r_td[k] <= r_td[k-1];
        end
    end

    // momentum h = I w
    logic signed [HP-1:0] h_prod [3][3];
    logic signed [HW-1:0] r_h    [3];

    for (genvar i = 0; i < 3; i++) begin : g_hrow
        for (genvar j = 0; j < 3; j++) begin : g_hcol
            rbaa_mul #(.A_BITS(MW), .B_BITS(W)) u_mul (
                .i_clk (i_clk), .i_en (en), .i_a (m[i][j]), .i_b (r_w1[j]),
                .o_p (h_prod[i][j])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_h[i] <= HW'(h_prod[i][0]) + HW'(h_prod[i][1]) + HW'(h_prod[i][2]);
            end
        end
    end

    // gyroscopic term g = w x h, then net torque
    logic signed [GP-1:0] g_prod [3][2];
    logic signed [GW-1:0] r_g    [3];
    logic signed [NW-1:0] r_net  [3];

    for (genvar i = 0; i < 3; i++) begin : g_gyro
        localparam int unsigned IA = (i + 1) % 3;
        localparam int unsigned IB = (i + 2) % 3;
        rbaa_mul #(.A_BITS(W), .B_BITS(HW)) u_mul_p (
            .i_clk (i_clk), .i_en (en), .i_a (r_wd[DLY_W-1][IA]), .i_b (r_h[IB]),
            .o_p (g_prod[i][0])
        );
        rbaa_mul #(.A_BITS(W), .B_BITS(HW)) u_mul_q (
            .i_clk (i_clk), .i_en (en), .i_a (r_wd[DLY_W-1][IB]), .i_b (r_h[IA]),
            .o_p (g_prod[i][1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_g[i]   <= GW'(g_prod[i][0]) - GW'(g_prod[i][1]);
                r_net[i] <= (NW'(r_td[DLY_T-1][i]) <<< (2 * FRAC_BITS)) - NW'(r_g[i]);
            end
        end
    end

    // numerator adj(I) * net
    logic signed [UP-1:0] u_prod [3][3];
    logic signed [UW-1:0] r_num  [3];

    for (genvar i = 0; i < 3; i++) begin : g_nrow
        for (genvar j = 0; j < 3; j++) begin : g_ncol
            rbaa_mul #(.A_BITS(CW), .B_BITS(NW)) u_mul (
                .i_clk (i_clk), .i_en (en), .i_a (c[i][j]), .i_b (r_net[j]),
                .o_p (u_prod[i][j])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= UW'(u_prod[i][0]) + UW'(u_prod[i][1]) + UW'(u_prod[i][2]);
            end
        end
    end

    logic signed [W-1:0] quo  [3];
    logic                qsat [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        rbaa_div #(.WORD_BITS(W), .NUM_BITS(UW), .DEN_BITS(DMW)) u_div (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_num     (r_num[i]),
            .i_den_mag (r_den_mag),
            .i_den_neg (r_den_neg),
            .o_quo     (quo[i]),
            .o_sat     (qsat[i])
        );
    end

    // output register
    logic signed [W-1:0] r_acc [3];
    logic                r_out_sing;
    logic                r_out_sat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_sing) begin
                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                r_out_sing <= 1'b1;
                r_out_sat  <= 1'b0;
            end else begin
                for (int i = 0; i < 3; i++) r_acc[i] <= quo[i];
                r_out_sing <= 1'b0;
                r_out_sat  <= qsat[0] | qsat[1] | qsat[2];
            end
        end
    end

    assign o_out_valid = r_vld[P_O];
    assign o_accel_x   = r_acc[0];
    assign o_accel_y   = r_acc[1];
    assign o_accel_z   = r_acc[2];
    assign o_singular  = r_out_sing;
    assign o_saturated = r_out_sat;

endmodule
`default_nettype wire

@@ test/tb_rigid_body_angular_acceleration.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rigid_body_angular_acceleration
// Drives torque and rate items through the Euler rotation block under several
// inertia tensors and checks each acceleration item against an exact
// wide-integer predictor or against a typed expected value.
// ----------------------------------------------------------------------------
module tb_rigid_body_angular_acceleration;
    import rbaa_pkg::*;

    localparam int W = RBAA_WORD_BITS;
    localparam int F = RBAA_FRAC_BITS;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 80;

    typedef logic signed [255:0] wide_t;
    typedef logic [W-1:0] word_t;

    typedef struct {
        word_t tq[3];
        word_t rt[3];
    } body_in_t;

    typedef struct {
        word_t ax, ay, az;
        logic  sing, sat;
    } accel_t;

    typedef struct {
        int       preset;
        body_in_t b;
        bit       typed;
        accel_t   want;
    } row_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [W-1:0] i_cfg_data = '0;
    logic i_in_valid = 0;
    logic o_in_stall;
    logic signed [W-1:0] i_torque_x = '0, i_torque_y = '0, i_torque_z = '0;
    logic signed [W-1:0] i_rate_x = '0, i_rate_y = '0, i_rate_z = '0;
    logic o_out_valid;
    logic i_out_stall = 0;
    logic signed [W-1:0] o_accel_x, o_accel_y, o_accel_z;
    logic o_singular, o_saturated;

    rigid_body_angular_acceleration dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    word_t  inertia [NUM_CFG];
    accel_t accel_q[$];
    int     errors = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     singular_seen = 0;
    int     sat_seen = 0;
    int     cycles = 0;
    int     snd_idle_pct = 0;
    int     rcv_idle_pct = 0;
    bit     hold_req = 0;
    int     hold_cnt = 0;

    function automatic wide_t sx(input word_t v);
        return {{(256-W){v[W-1]}}, v};
    endfunction

    function automatic wide_t zx(input word_t v);
        return {{(256-W){1'b0}}, v};
    endfunction

    // round half away from zero, then clip to the word range
    function automatic word_t round_clip(input wide_t n, input wide_t d, inout logic sat);
        logic [255:0] na, da, q, lim;
        logic neg;
        neg = n[255] ^ d[255];
        na = n[255] ? -n : n;
        da = d[255] ? -d : d;
        q = (2 * na + da) / (2 * da);
        lim = neg ? (256'd1 << (W-1)) : ((256'd1 << (W-1)) - 1);
        if (q > lim) begin
            q = lim;
            sat = 1;
        end
        return neg ? word_t'(-q) : word_t'(q);
    endfunction

    function automatic accel_t euler_accel(input body_in_t b);
        wide_t m[3][3], w[3], tau[3], h[3], g[3], nt[3], c[3][3];
        wide_t det, den, num;
        word_t a[3];
        accel_t r;
        logic sat;
        sat = 0;
        m[0][0] = zx(inertia[CFG_IXX]);
        m[1][1] = zx(inertia[CFG_IYY]);
        m[2][2] = zx(inertia[CFG_IZZ]);
        m[0][1] = sx(inertia[CFG_IXY]);
        m[0][2] = sx(inertia[CFG_IXZ]);
        m[1][2] = sx(inertia[CFG_IYZ]);
        m[1][0] = m[0][1];
        m[2][0] = m[0][2];
        m[2][1] = m[1][2];
        for (int i = 0; i < 3; i++) begin
            tau[i] = sx(b.tq[i]);
            w[i] = sx(b.rt[i]);
        end
        for (int i = 0; i < 3; i++) begin
            h[i] = 0;
            for (int j = 0; j < 3; j++) h[i] = h[i] + m[i][j] * w[j];
        end
        g[0] = w[1] * h[2] - w[2] * h[1];
        g[1] = w[2] * h[0] - w[0] * h[2];
        g[2] = w[0] * h[1] - w[1] * h[0];
        for (int i = 0; i < 3; i++) nt[i] = (tau[i] <<< (2*F)) - g[i];
        c[0][0] = m[1][1] * m[2][2] - m[1][2] * m[1][2];
        c[1][1] = m[0][0] * m[2][2] - m[0][2] * m[0][2];
        c[2][2] = m[0][0] * m[1][1] - m[0][1] * m[0][1];
        c[0][1] = m[0][2] * m[1][2] - m[0][1] * m[2][2];
        c[0][2] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
        c[1][2] = m[0][1] * m[0][2] - m[0][0] * m[1][2];
        c[1][0] = c[0][1];
        c[2][0] = c[0][2];
        c[2][1] = c[1][2];
        det = 0;
        for (int j = 0; j < 3; j++) det = det + m[0][j] * c[0][j];
        if (det == 0) begin
            r = '{ax: '0, ay: '0, az: '0, sing: 1'b1, sat: 1'b0};
            return r;
        end
        den = det <<< F;
        for (int i = 0; i < 3; i++) begin
            num = 0;
            for (int j = 0; j < 3; j++) num = num + c[i][j] * nt[j];
            a[i] = round_clip(num, den, sat);
        end
        r = '{ax: a[0], ay: a[1], az: a[2], sing: 1'b0, sat: sat};
        return r;
    endfunction

    task automatic report(input string what, input word_t got, input word_t want);
        errors++;
        $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
    endtask

    // result checker, samples at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            accel_t e;
            if (accel_q.size() == 0) begin
                report("unexpected item", o_accel_x, '0);
            end else begin
                e = accel_q.pop_front();
                if (o_accel_x !== e.ax) report("accel_x", o_accel_x, e.ax);
                if (o_accel_y !== e.ay) report("accel_y", o_accel_y, e.ay);
                if (o_accel_z !== e.az) report("accel_z", o_accel_z, e.az);
                if (o_singular !== e.sing) report("singular", o_singular, e.sing);
                if (o_saturated !== e.sat) report("saturated", o_saturated, e.sat);
                singular_seen += e.sing;
                sat_seen += e.sat;
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_rigid_body_angular_acceleration: done, errors");
            $finish;
        end
    end

    // receiver side: random stall, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_cnt = 400;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall = 1;
        end else begin
            i_out_stall = ($urandom_range(99) < rcv_idle_pct);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input word_t v);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        inertia[idx] = v;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // sender goes idle, then waits for every expected item to come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 0;
        wait (accel_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_tensor(input word_t v[NUM_CFG]);
        drain();
        for (int i = 0; i < NUM_CFG; i++) write_reg(t_cfg_idx'(i), v[i]);
    endtask

    task automatic load_preset(input int p);
        word_t v[NUM_CFG];
        case (p)
            0: v = '{IXX_RESET_INT << F, IYY_RESET_INT << F, IZZ_RESET_INT << F, 0, 0, 0};
            1: v = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0};
            2: v = '{32'h0000_0001, 32'h0001_0000, 32'h0001_0000, 0, 0, 0};
            3: v = '{0, 0, 0, 0, 0, 0};
            4: v = '{'1, '1, '1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            default: v = '{'1, '1, '1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        endcase
        load_tensor(v);
    endtask

    task automatic send(input body_in_t b, input bit typed, input accel_t want);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_in_valid = 1;
        i_torque_x = b.tq[0];
        i_torque_y = b.tq[1];
        i_torque_z = b.tq[2];
        i_rate_x = b.rt[0];
        i_rate_y = b.rt[1];
        i_rate_z = b.rt[2];
        do @(posedge i_clk); while (o_in_stall);
        accel_q.push_back(typed ? want : euler_accel(b));
        items_sent++;
    endtask

    function automatic word_t rand_field();
        case ($urandom_range(3))
            0: return $urandom;
            1: return word_t'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
            2: return word_t'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
            default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    function automatic word_t rand_diag();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1, 32'h0100_0000);
            default: return $urandom_range(32'h0010_0000, 32'h0200_0000);
        endcase
    endfunction

    function automatic word_t rand_product();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 0;
            default: return word_t'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    localparam accel_t ZERO_RES = '{ax: '0, ay: '0, az: '0, sing: 1'b0, sat: 1'b0};
    localparam accel_t SING_RES = '{ax: '0, ay: '0, az: '0, sing: 1'b1, sat: 1'b0};
    localparam word_t MAXW = 32'h7fff_ffff;
    localparam word_t MINW = 32'h8000_0000;
    localparam accel_t NONE = ZERO_RES;

    row_t dir_rows[$] = '{
        '{0, '{'{0, 0, 0}, '{0, 0, 0}}, 1, ZERO_RES},
        '{0, '{'{MAXW, MAXW, MAXW}, '{0, 0, 0}}, 0, NONE},
        '{0, '{'{MINW, MINW, MINW}, '{0, 0, 0}}, 0, NONE},
        '{0, '{'{0, 0, 0}, '{MAXW, MAXW, MAXW}}, 0, NONE},
        '{0, '{'{0, 0, 0}, '{MINW, MAXW, MINW}}, 0, NONE},
        '{0, '{'{32'h0001_0000, 0, 0}, '{0, 32'h0000_8000, 32'hffff_0000}}, 0, NONE},
        '{1, '{'{MAXW, MINW, 32'h0001_0000}, '{0, 0, 0}}, 1,
             '{ax: MAXW, ay: MINW, az: 32'h0001_0000, sing: 1'b0, sat: 1'b0}},
        '{1, '{'{0, 0, 0}, '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}}, 0, NONE},
        '{1, '{'{MAXW, MAXW, MAXW}, '{MINW, MINW, MINW}}, 0, NONE},
        '{2, '{'{MAXW, 0, 0}, '{0, 0, 0}}, 1,
             '{ax: MAXW, ay: '0, az: '0, sing: 1'b0, sat: 1'b1}},
        '{2, '{'{MINW, 0, 0}, '{0, 0, 0}}, 1,
             '{ax: MINW, ay: '0, az: '0, sing: 1'b0, sat: 1'b1}},
        '{2, '{'{32'hffff_ffff, 0, 0}, '{0, 0, 0}}, 1,
             '{ax: 32'hffff_0000, ay: '0, az: '0, sing: 1'b0, sat: 1'b0}},
        '{3, '{'{MAXW, MINW, 1}, '{MAXW, 1, MINW}}, 1, SING_RES},
        '{3, '{'{0, 0, 0}, '{0, 0, 0}}, 1, SING_RES},
        '{4, '{'{MAXW, MINW, MAXW}, '{MAXW, MINW, MAXW}}, 0, NONE},
        '{4, '{'{32'h1234_5678, 32'hfedc_ba98, 0}, '{1, 32'hffff_ffff, 0}}, 0, NONE},
        '{5, '{'{MINW, MAXW, MINW}, '{MINW, MAXW, MINW}}, 0, NONE},
        '{5, '{'{32'h0001_0000, 0, 0}, '{32'h0001_0000, 0, 0}}, 0, NONE}
    };

    initial begin
        int cur;
        word_t v[NUM_CFG];
        body_in_t b;
        load_defaults: for (int i = 0; i < NUM_CFG; i++) inertia[i] = 0;
        inertia[CFG_IXX] = IXX_RESET_INT << F;
        inertia[CFG_IYY] = IYY_RESET_INT << F;
        inertia[CFG_IZZ] = IZZ_RESET_INT << F;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        cur = 0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].preset != cur) begin
                cur = dir_rows[k].preset;
                load_preset(cur);
            end
            send(dir_rows[k].b, dir_rows[k].typed, dir_rows[k].want);
        end

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 1) begin
                load_preset(0);
            end else if (ph == 4) begin
                // one row and column of zeros: singular tensor
                v = '{0, rand_diag(), rand_diag(), 0, 0, rand_product()};
                load_tensor(v);
            end else begin
                v = '{rand_diag(), rand_diag(), rand_diag(),
                      rand_product(), rand_product(), rand_product()};
                load_tensor(v);
            end
            snd_idle_pct = (ph < 3) ? 6 : (ph < 6) ? 50 : 0;
            rcv_idle_pct = (ph < 3) ? 50 : (ph < 6) ? 6 : 0;
            // long receiver hold-off so the pipeline fills and stalls the input
            if (ph == 2 || ph == 7) hold_req = 1;
            for (int n = 0; n < 220; n++) begin
                for (int i = 0; i < 3; i++) begin
                    b.tq[i] = rand_field();
                    b.rt[i] = rand_field();
                end
                send(b, 0, NONE);
            end
        end

        @(negedge i_clk);
        i_in_valid = 0;
        drain();
        $display("%0d items through 6 fixed tensors and 9 random phases, %0d results",
                 items_sent, results_seen);
        $display("%0d singular and %0d clipped results, %0d mismatches",
                 singular_seen, sat_seen, errors);
        if (errors == 0) begin
            $display("tb_rigid_body_angular_acceleration: done, clean");
        end else begin
            $display("tb_rigid_body_angular_acceleration: done, errors");
        end
        $finish;
    end

endmodule
